// File: rtl/core/slpg_pkg.sv
`default_nettype none

package slpg_pkg;

  // Phase counter width and configuration register width
  localparam int DUR_W = 12;
  localparam int CFG_W = 12;
  localparam int CMP_W = (CFG_W > DUR_W) ? CFG_W : DUR_W;
  localparam int DUR_MAX = (1 << DUR_W) - 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FLICKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE   = 2'd2;

  localparam logic [CFG_W-1:0] FLICKER_RST = 12'd50;
  localparam logic [CFG_W-1:0] FLASH_RST   = 12'd200;
  localparam logic [CFG_W-1:0] PAUSE_RST   = 12'd1000;

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Status codes that select a flash pattern on the error indicator
  localparam logic [15:0] CODE_NONE     = 16'h0000;
  localparam logic [15:0] CODE_SINGLE_A = 16'h002D;
  localparam logic [15:0] CODE_SINGLE_B = 16'h0032;
  localparam logic [15:0] CODE_DOUBLE   = 16'h001B;

  typedef enum logic [2:0] {
    PAT_OFF     = 3'd0,
    PAT_ON      = 3'd1,
    PAT_FLICKER = 3'd2,
    PAT_BLINK   = 3'd3,
    PAT_SINGLE  = 3'd4,
    PAT_DOUBLE  = 3'd5
  } pat_t;

  typedef struct packed {
    logic [CFG_W-1:0] flicker_half_ms;
    logic [CFG_W-1:0] flash_ms;
    logic [CFG_W-1:0] pause_ms;
  } cfg_t;

  // A zero length counts as one tick, a length beyond the counter saturates
  function automatic logic [DUR_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [DUR_W-1:0] r;
    if (v == '0) begin
      r = DUR_W'(1);
    end else if (CMP_W'(v) > CMP_W'(DUR_MAX)) begin
      r = DUR_W'(DUR_MAX);
    end else begin
      r = DUR_W'(v);
    end
    return r;
  endfunction

  function automatic logic [2:0] phase_count(input pat_t p);
    logic [2:0] n;
    case (p)
      PAT_DOUBLE: n = 3'd4;
      PAT_FLICKER, PAT_BLINK, PAT_SINGLE: n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic pat_t select_run(input logic [4:0] s);
    pat_t p;
    if (s[3]) begin
      p = PAT_ON;
    end else if (s[0]) begin
      p = PAT_OFF;
    end else if (s[1]) begin
      p = PAT_BLINK;
    end else if (s[2]) begin
      p = PAT_SINGLE;
    end else if (|s[1:0]) begin
      p = PAT_FLICKER;
    end else begin
      p = PAT_OFF;
    end
    return p;
  endfunction

  function automatic pat_t select_err(input logic [4:0] s, input logic [15:0] code,
                                      input logic boot);
    pat_t p;
    if ((|s[1:0]) && boot) begin
      p = PAT_FLICKER;
    end else if (code == CODE_NONE || !s[4]) begin
      p = PAT_OFF;
    end else if (code == CODE_SINGLE_A || code == CODE_SINGLE_B) begin
      p = PAT_SINGLE;
    end else if (code == CODE_DOUBLE) begin
      p = PAT_DOUBLE;
    end else if (s[4] || s[0]) begin
      p = PAT_FLICKER;
    end else begin
      p = PAT_BLINK;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/slpg_engine.sv
`default_nettype none

module slpg_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire slpg_pkg::pat_t sel,
  input  wire slpg_pkg::cfg_t cfg,
  output logic               lit
);
  import slpg_pkg::*;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] len;
  } load_t;

  pat_t             pattern, pattern_next, pat_a;
  logic [1:0]       phase, phase_next, ph_a;
  logic [DUR_W-1:0] remaining, remaining_next, rem_a, rem_b;
  logic             level, level_next, lvl_a;
  load_t            ld0, ld1;

  // Level and length of one phase of a pattern
  function automatic load_t load_phase(input pat_t p, input logic [1:0] ph,
                                       input logic cur, input cfg_t c);
    load_t r;
    logic [CFG_W-1:0] len;
    logic lv;
    len = c.pause_ms;
    lv  = ~ph[0];
    case (p)
      PAT_OFF:     lv = 1'b0;
      PAT_ON:      lv = 1'b1;
      PAT_FLICKER: len = c.flicker_half_ms;
      PAT_BLINK:   len = c.flash_ms;
      PAT_SINGLE:  len = (ph == 2'd0) ? c.flash_ms : c.pause_ms;
      PAT_DOUBLE:  len = (ph == 2'd3) ? c.pause_ms : c.flash_ms;
      default:     lv = cur;
    endcase
    r.level = lv;
    r.len   = clamp_len(len);
    return r;
  endfunction

  always_comb begin
    pat_a = pattern;
    ph_a  = phase;
    lvl_a = level;
    rem_a = remaining;
    ld0   = load_phase(sel, 2'd0, level, cfg);
    // Idle engine: sample the selection and start the first phase
    if (remaining == '0) begin
      pat_a = sel;
      ph_a  = 2'd0;
      lvl_a = ld0.level;
      rem_a = ld0.len;
    end
    lit = lvl_a;
    rem_b = rem_a - DUR_W'(1);
    pattern_next   = pat_a;
    phase_next     = ph_a;
    level_next     = lvl_a;
    remaining_next = rem_b;
    ld1 = load_phase(pat_a, ph_a + 2'd1, lvl_a, cfg);
    // Phase over with more to play: load the next one
    if (rem_b == '0 && ({1'b0, ph_a} + 3'd1) < phase_count(pat_a)) begin
      phase_next     = ph_a + 2'd1;
      level_next     = ld1.level;
      remaining_next = ld1.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern   <= PAT_OFF;
      phase     <= 2'd0;
      remaining <= '0;
      level     <= 1'b0;
    end else if (adv) begin
      pattern   <= pattern_next;
      phase     <= phase_next;
      remaining <= remaining_next;
      level     <= level_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/status_led_pattern_generator.sv
`default_nettype none

// Status indicator pattern generator for a RUN and an ERROR indicator.
// Feed one request per millisecond tick on the s_ stream: the status bits,
// the status code and the boot-failed flag. Each request yields exactly one
// result on the m_ stream carrying whether RUN and ERROR are lit in that
// tick (1 = lit; pin polarity is left to the board).
// Each engine samples the inputs only when idle, picks off, on, flicker,
// blink, single or double flash, and plays the whole phase sequence before
// sampling again. Phase lengths come from three 12-bit registers written
// over the cfg_ channel (flicker half period, flash phase, pause); a change
// takes effect when the next phase loads. Write them only while idle.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while the result register is free; the
// engine update between the two registers is combinational.
// Reset clears both engines to idle and unlit, empties both registers and
// restores the register defaults 50, 200 and 1000 ticks.
// When the receiver stalls, the result holds and the input register keeps
// one further request; s_tready then drops until the result is taken.
module status_led_pattern_generator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [4:0] status, [20:5] al_error, [21] boot_fail, [23:22] zero
  input  wire logic [slpg_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] run_led_on, [1] err_led_on, [7:2] zero
  output logic [slpg_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [slpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [slpg_pkg::CFG_W-1:0]        cfg_data
);
  import slpg_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic [4:0]  in_status;
  logic [15:0] in_code;
  logic        in_boot;
  logic        out_adv;
  logic        adv;
  logic        run_lit;
  logic        err_lit;
  pat_t        run_sel;
  pat_t        err_sel;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flicker_half_ms <= FLICKER_RST;
      cfg.flash_ms        <= FLASH_RST;
      cfg.pause_ms        <= PAUSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLICKER: cfg.flicker_half_ms <= cfg_data;
        REG_FLASH:   cfg.flash_ms        <= cfg_data;
        REG_PAUSE:   cfg.pause_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register frees up when empty or being taken
  assign out_adv  = !m_tvalid || m_tready;
  assign adv      = in_valid && out_adv;
  assign s_tready = !in_valid || out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_status <= s_tdata[4:0];
      in_code   <= s_tdata[20:5];
      in_boot   <= s_tdata[21];
    end
  end

  assign run_sel = select_run(in_status);
  assign err_sel = select_err(in_status, in_code, in_boot);

  // Engines advance by one tick as the request moves to the result register
  slpg_engine u_run (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .sel (run_sel),
    .cfg (cfg),
    .lit (run_lit)
  );

  slpg_engine u_err (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .sel (err_sel),
    .cfg (cfg),
    .lit (err_lit)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {{(OUT_DATA_W - 2){1'b0}}, err_lit, run_lit};
    end
  end

`ifndef NO_ASSERTIONS
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("registers not empty after reset");
  a_adv_fills: assert property (@(posedge clk) disable iff (rst) adv |=> m_tvalid)
    else $error("advanced request did not reach the result register");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_adv) |=> in_valid)
    else $error("stalled request lost from the input register");
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid))
    else $error("input stalled while a stage is free");
`endif

endmodule

`default_nettype wire

// File: test/status_led_pattern_generator_tb.sv
`timescale 1ns / 100ps

module status_led_pattern_generator_tb;
  import slpg_pkg::*;

  // Index past the last register; writes to it must leave every length alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Receiver hold-off long enough to fill the block and stall its input
  localparam int HOLD_CYCLES = 300;
  // Cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT = 3000;

  // One request: fields from the highest bit down, as packed onto s_tdata
  typedef struct packed {
    logic        boot;
    logic [15:0] code;
    logic [4:0]  status;
  } tick_t;

  // Expected lit levels for one tick, run indicator in bit 0
  typedef struct packed {
    logic err;
    logic run;
  } led_t;

  // Predicts both indicator engines and checks results in request order
  class led_scoreboard;
    typedef struct {
      pat_t             pat;
      logic [1:0]       phase;
      logic [DUR_W-1:0] left;
      logic             lit;
    } engine_t;

    logic [CFG_W-1:0] flicker_len;
    logic [CFG_W-1:0] flash_len;
    logic [CFG_W-1:0] pause_len;
    engine_t          run_eng;
    engine_t          err_eng;
    led_t             due_q[$];
    int               ticks;
    int               checked;
    int               writes;
    int               errors;
    int               run_picks[8];
    int               err_picks[8];

    function new();
      flicker_len = FLICKER_RST;
      flash_len   = FLASH_RST;
      pause_len   = PAUSE_RST;
      run_eng     = '{PAT_OFF, 2'd0, '0, 1'b0};
      err_eng     = '{PAT_OFF, 2'd0, '0, 1'b0};
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      writes++;
      case (idx)
        REG_FLICKER: flicker_len = val;
        REG_FLASH:   flash_len = val;
        REG_PAUSE:   pause_len = val;
        default: ;
      endcase
    endfunction

    // A zero length still lasts one tick
    function logic [DUR_W-1:0] span(logic [CFG_W-1:0] v);
      return (v == '0) ? DUR_W'(1) : DUR_W'(v);
    endfunction

    function int phase_total(pat_t p);
      case (p)
        PAT_DOUBLE: return 4;
        PAT_FLICKER, PAT_BLINK, PAT_SINGLE: return 2;
        default: return 1;
      endcase
    endfunction

    // Even phases are lit, odd ones dark, unless the pattern is steady
    function void load(inout engine_t e, input logic [1:0] ph);
      logic [CFG_W-1:0] len;
      logic             kept;
      kept = e.lit;
      len = pause_len;
      e.phase = ph;
      e.lit = ~ph[0];
      case (e.pat)
        PAT_OFF:     e.lit = 1'b0;
        PAT_ON:      e.lit = 1'b1;
        PAT_FLICKER: len = flicker_len;
        PAT_BLINK:   len = flash_len;
        PAT_SINGLE:  len = (ph == 2'd0) ? flash_len : pause_len;
        PAT_DOUBLE:  len = (ph == 2'd3) ? pause_len : flash_len;
        default:     e.lit = kept;
      endcase
      e.left = span(len);
    endfunction

    function pat_t run_choice(logic [4:0] s);
      if (s[3]) return PAT_ON;
      if (s[0]) return PAT_OFF;
      if (s[1]) return PAT_BLINK;
      if (s[2]) return PAT_SINGLE;
      if (s[1:0] != 2'b00) return PAT_FLICKER;
      return PAT_OFF;
    endfunction

    function pat_t err_choice(logic [4:0] s, logic [15:0] code, logic boot);
      if (s[1:0] != 2'b00 && boot) return PAT_FLICKER;
      if (code == CODE_NONE || !s[4]) return PAT_OFF;
      if (code == CODE_SINGLE_A || code == CODE_SINGLE_B) return PAT_SINGLE;
      if (code == CODE_DOUBLE) return PAT_DOUBLE;
      if (s[4] || s[0]) return PAT_FLICKER;
      return PAT_BLINK;
    endfunction

    // Sample the choice only when idle, report this tick's level, then count down
    function logic advance(inout engine_t e, input pat_t pick, output bit picked);
      logic lvl;
      picked = (e.left == '0);
      if (picked) begin
        e.pat = pick;
        load(e, 2'd0);
      end
      lvl = e.lit;
      e.left = e.left - 1'b1;
      if (e.left == '0 && int'(e.phase) + 1 < phase_total(e.pat)) begin
        load(e, e.phase + 2'd1);
      end
      return lvl;
    endfunction

    function void note_tick(tick_t t);
      led_t due;
      bit   hit;
      due.run = advance(run_eng, run_choice(t.status), hit);
      if (hit) run_picks[run_eng.pat]++;
      due.err = advance(err_eng, err_choice(t.status, t.code, t.boot), hit);
      if (hit) err_picks[err_eng.pat]++;
      due_q.push_back(due);
      ticks++;
    endfunction

    task report(string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_led(logic [OUT_DATA_W-1:0] data);
      led_t due;
      if (due_q.size() == 0) begin
        report($sformatf("result 0x%0h arrived with no request outstanding", data));
        return;
      end
      due = due_q.pop_front();
      checked++;
      if (data[0] !== due.run) begin
        report($sformatf("result %0d run_led_on %b, predicted %b", checked, data[0], due.run));
      end
      if (data[1] !== due.err) begin
        report($sformatf("result %0d err_led_on %b, predicted %b", checked, data[1], due.err));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [4:0] status, [20:5] al_error, [21] boot_fail, [23:22] zero
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] run_led_on, [1] err_led_on, [7:2] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  led_scoreboard sb = new();
  bit            steady = 1'b0;    // no gaps on either side while set
  bit            hold_off = 1'b0;  // ask the receiver for one long stall
  tick_t         recent = '0;
  int            quiet_cycles = 0;

  status_led_pattern_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random tick; hold the previous one now and then, as a real status would,
  // and lean the status code towards the values that pick a flash pattern
  function automatic tick_t next_tick();
    tick_t t;
    int    r;
    if ($urandom_range(0, 99) < 30) return recent;
    t.status = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      t.code = CODE_NONE;
    end else if (r < 32) begin
      t.code = CODE_SINGLE_A;
    end else if (r < 44) begin
      t.code = CODE_SINGLE_B;
    end else if (r < 58) begin
      t.code = CODE_DOUBLE;
    end else begin
      t.code = 16'($urandom);
    end
    t.boot = 1'($urandom_range(0, 1));
    recent = t;
    return t;
  endfunction

  // Offer one request after a random gap; keep tvalid high across back-to-back requests
  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, t};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(t);
  endtask

  task automatic send_status(input logic [4:0] s, input logic [15:0] code, input logic boot);
    send_tick('{boot: boot, code: code, status: s});
  endtask

  task automatic send_random(input int n);
    repeat (n) send_tick(next_tick());
  endtask

  // Drop the request line and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_lengths(input logic [CFG_W-1:0] flicker, input logic [CFG_W-1:0] flash,
                             input logic [CFG_W-1:0] pause);
    set_reg(REG_FLICKER, flicker);
    set_reg(REG_FLASH, flash);
    set_reg(REG_PAUSE, pause);
    set_reg(REG_SPARE, 12'($urandom));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        m_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Check every result taken off the output stream
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_led(m_tdata);
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, sb.pending());
      $display("FAIL status_led_pattern_generator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset lengths: RUN starts a blink and ERROR a flicker on the first tick.
    // Stop one tick short of the end of the long lit blink phase, so the
    // next write lands mid-pattern and the dark phase loads the new length.
    repeat (199) send_status(5'h02, 16'($urandom), 1'b1);
    drain();

    // Zero lengths behave as single ticks; send a fixed list of statuses across the selection branches
    set_lengths(12'd0, 12'd0, 12'd0);
    set_reg(REG_SPARE, 12'hFFF);
    send_status(5'h02, 16'h0000, 1'b1);
    send_status(5'h08, CODE_NONE, 1'b0);
    send_status(5'h08, CODE_NONE, 1'b0);
    send_status(5'h01, CODE_SINGLE_A, 1'b0);
    send_status(5'h11, CODE_SINGLE_A, 1'b0);
    send_status(5'h11, CODE_SINGLE_A, 1'b0);
    send_status(5'h12, CODE_SINGLE_B, 1'b0);
    send_status(5'h12, CODE_SINGLE_B, 1'b0);
    send_status(5'h14, CODE_DOUBLE, 1'b0);
    send_status(5'h14, CODE_DOUBLE, 1'b0);
    send_status(5'h10, 16'hFFFF, 1'b0);
    send_status(5'h10, 16'hFFFF, 1'b0);
    send_status(5'h03, 16'h1234, 1'b1);
    send_status(5'h03, 16'h1234, 1'b1);
    send_status(5'h1F, 16'hFFFF, 1'b1);
    send_status(5'h00, 16'h0000, 1'b0);
    send_status(5'h0F, CODE_SINGLE_A, 1'b0);
    send_status(5'h0F, CODE_DOUBLE, 1'b0);
    send_status(5'h1C, CODE_DOUBLE, 1'b1);
    send_status(5'h1C, CODE_DOUBLE, 1'b1);
    send_status(5'h04, 16'h8000, 1'b0);
    send_status(5'h04, 16'h8000, 1'b0);
    send_status(5'h02, 16'h0001, 1'b1);
    drain();

    // One-tick phases: run the first stretch with no gaps at all
    set_lengths(12'd1, 12'd1, 12'd1);
    steady = 1'b1;
    send_random(80);
    steady = 1'b0;
    send_random(150);
    drain();

    // Short uneven lengths; the receiver stalls long while requests keep coming
    set_lengths(12'd2, 12'd3, 12'd5);
    hold_off = 1'b1;
    send_random(230);
    drain();

    set_lengths(12'($urandom_range(1, 12)), 12'($urandom_range(1, 12)),
                12'($urandom_range(1, 12)));
    send_random(230);
    drain();

    // Full-scale lengths: each engine settles into one long phase
    set_lengths(12'hFFF, 12'hFFF, 12'hFFF);
    send_random(60);
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d ticks under reset, zero, one-tick, short and full-scale lengths;",
             sb.ticks);
    $display("%0d results compared, %0d register writes; RUN picks off/on/blink/single %0d/%0d/%0d/%0d,",
             sb.checked, sb.writes, sb.run_picks[PAT_OFF], sb.run_picks[PAT_ON],
             sb.run_picks[PAT_BLINK], sb.run_picks[PAT_SINGLE]);
    $display("ERROR picks off/flicker/single/double %0d/%0d/%0d/%0d",
             sb.err_picks[PAT_OFF], sb.err_picks[PAT_FLICKER],
             sb.err_picks[PAT_SINGLE], sb.err_picks[PAT_DOUBLE]);
    if (sb.errors == 0) begin
      $display("PASS status_led_pattern_generator");
    end else begin
      $display("FAIL status_led_pattern_generator");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/slpg_pkg.sv
rtl/core/slpg_engine.sv
rtl/core/status_led_pattern_generator.sv
test/status_led_pattern_generator_tb.sv
